### src/rrc_pkg.sv
package rrc_pkg;

   // fixed field widths
   localparam int TIME_W      = 32;
   localparam int OPCODE_W    = 3;
   localparam int MODE_W      = 2;
   localparam int PULSE_W     = 9;
   localparam int COOLDOWN_W  = 11;
   localparam int FOLLOW_W    = 10;
   localparam int IDLE_W      = 22;
   localparam int RSP_BITS    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 22;

   localparam int PLAYERS_DEFAULT = 2;

   // relay modes
   localparam logic [MODE_W-1:0] MODE_DISABLED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PULSE    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FOLLOW   = 2'd2;

   // event opcodes
   localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PRESS    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_RELEASE  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_ACTIVITY = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_ALL_OFF  = 3'd4;

   // csr indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RELAY_MODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LOW    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_TIME    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN_TIME = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOLLOW_LIMIT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_LIMIT    = 3'd5;

   // csr reset values
   localparam logic [MODE_W-1:0]     RESET_RELAY_MODE    = MODE_PULSE;
   localparam logic                  RESET_ACTIVE_LOW    = 1'b1;
   localparam logic [PULSE_W-1:0]    RESET_PULSE_TIME    = 9'd60;
   localparam logic [COOLDOWN_W-1:0] RESET_COOLDOWN_TIME = 11'd120;
   localparam logic [FOLLOW_W-1:0]   RESET_FOLLOW_LIMIT  = 10'd250;
   localparam logic [IDLE_W-1:0]     RESET_IDLE_LIMIT    = 22'd300000;

   // per-word event info shared by all players
   typedef struct packed {
      logic                step;
      logic [OPCODE_W-1:0] opcode;
      logic                maint;
      logic [MODE_W-1:0]   mode;
      logic [TIME_W-1:0]   now;
      logic                clear;
   } evt_type;

   typedef struct packed {
      logic [PULSE_W-1:0]    pulse_time;
      logic [COOLDOWN_W-1:0] cooldown_time;
      logic [FOLLOW_W-1:0]   follow_limit;
      logic [IDLE_W-1:0]     idle_limit;
   } cfg_type;

   typedef struct packed {
      logic on;
      logic armed;
      logic disarm;
      logic cutoff;
   } pstat_type;

   // deadline reached when now - deadline is not negative as a signed value
   function automatic logic reached(input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] deadline);
      logic [TIME_W-1:0] diff;
      diff = now - deadline;
      return ~diff[TIME_W-1];
   endfunction

endpackage

### src/rrc_if.sv
interface rrc_req_if;
   logic                          valid;
   logic                          ready;
   logic [rrc_pkg::OPCODE_W-1:0]  opcode;
   logic                          player;
   logic                          maintenance;

   modport source (output valid, output opcode, output player, output maintenance,
                   input ready);
   modport sink (input valid, input opcode, input player, input maintenance,
                 output ready);
endinterface

interface rrc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rrc_pkg::RSP_BITS-1:0]  relay_on;
   logic [rrc_pkg::RSP_BITS-1:0]  relay_pins;
   logic [rrc_pkg::RSP_BITS-1:0]  armed_flags;
   logic [rrc_pkg::RSP_BITS-1:0]  disarm_events;
   logic [rrc_pkg::RSP_BITS-1:0]  cutoff_events;

   modport source (output valid, output relay_on, output relay_pins, output armed_flags,
                   output disarm_events, output cutoff_events, input ready);
   modport sink (input valid, input relay_on, input relay_pins, input armed_flags,
                 input disarm_events, input cutoff_events, output ready);
endinterface

### src/rrc_player.sv
module rrc_player (
   input  logic               clock,
   input  logic               reset,
   input  logic               sel,
   input  rrc_pkg::evt_type   evt,
   input  rrc_pkg::cfg_type   cfg,
   output rrc_pkg::pstat_type stat
);

   logic                        on_ff, on_in;
   logic                        armed_ff, armed_in;
   logic [rrc_pkg::TIME_W-1:0]  last_ff, last_in;
   logic [rrc_pkg::TIME_W-1:0]  offd_ff, offd_in;
   logic [rrc_pkg::TIME_W-1:0]  cd_ff, cd_in;
   logic [rrc_pkg::TIME_W-1:0]  fs_ff, fs_in;

   logic                        act, fire, rel, disarm, cut;
   logic [rrc_pkg::TIME_W-1:0]  idle_span, follow_span;

   always_comb begin
      on_in    = on_ff;
      armed_in = armed_ff;
      last_in  = last_ff;
      offd_in  = offd_ff;
      cd_in    = cd_ff;
      fs_in    = fs_ff;
      disarm   = 1'b0;
      cut      = 1'b0;

      // activity re-arms
      act = sel && (evt.opcode == rrc_pkg::OP_PRESS || evt.opcode == rrc_pkg::OP_RELEASE
                    || evt.opcode == rrc_pkg::OP_ACTIVITY);
      if (act) begin
         last_in  = evt.now;
         armed_in = 1'b1;
      end

      fire = sel && evt.opcode == rrc_pkg::OP_PRESS && !evt.maint && armed_in
             && evt.mode != rrc_pkg::MODE_DISABLED && rrc_pkg::reached(evt.now, cd_ff);
      if (fire) begin
         on_in = 1'b1;
         cd_in = evt.now + rrc_pkg::TIME_W'(cfg.cooldown_time);
         if (evt.mode == rrc_pkg::MODE_PULSE) begin
            offd_in = evt.now + rrc_pkg::TIME_W'(cfg.pulse_time);
         end else begin
            fs_in = evt.now;
         end
      end

      rel = sel && evt.opcode == rrc_pkg::OP_RELEASE && evt.mode == rrc_pkg::MODE_FOLLOW;
      if (rel) begin
         on_in = 1'b0;
         cd_in = evt.now + rrc_pkg::TIME_W'(cfg.cooldown_time);
      end

      if (evt.opcode == rrc_pkg::OP_ALL_OFF) begin
         on_in = 1'b0;
      end

      // update pass: inactivity, pulse end, follow cutoff
      idle_span = evt.now - last_in;
      if (cfg.idle_limit != '0 && armed_in
          && idle_span >= rrc_pkg::TIME_W'(cfg.idle_limit)) begin
         disarm   = 1'b1;
         armed_in = 1'b0;
         on_in    = 1'b0;
      end

      follow_span = evt.now - fs_in;
      if (on_in) begin
         if (evt.mode == rrc_pkg::MODE_PULSE && rrc_pkg::reached(evt.now, offd_in)) begin
            on_in = 1'b0;
         end else if (evt.mode == rrc_pkg::MODE_FOLLOW
                      && follow_span >= rrc_pkg::TIME_W'(cfg.follow_limit)) begin
            on_in = 1'b0;
            cut   = 1'b1;
         end
      end

      stat.on     = on_in;
      stat.armed  = armed_in;
      stat.disarm = disarm;
      stat.cutoff = cut;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff    <= 1'b0;
         armed_ff <= 1'b1;
         last_ff  <= '0;
         offd_ff  <= '0;
         cd_ff    <= '0;
         fs_ff    <= '0;
      end else if (evt.step) begin
         on_ff    <= on_in;
         armed_ff <= armed_in;
         last_ff  <= last_in;
         offd_ff  <= offd_in;
         cd_ff    <= cd_in;
         fs_ff    <= fs_in;
      end else if (evt.clear) begin
         on_ff <= 1'b0;
      end
   end

endmodule

### src/recoil_relay_controller.sv
// recoil relay controller: drives one recoil relay per player
//
// req channel: one event word per handshake (opcode, player, maintenance);
//   opcodes are tick, trigger press, trigger release, activity and all off
// rsp channel: exactly one status word per event word, carrying for each
//   of the first two players the relay on flag, the pin level after
//   polarity, the armed flag and disarm / follow cutoff event bits
// csr port: write-only, csr_we with csr_index and csr_wdata, one register
//   per edge; writing the mode or polarity register turns every relay off;
//   only write while no event word is in flight
// latency: a word accepted at edge n shows up on rsp at edge n+1
// throughput: one word per cycle; each word goes through a single pass of
//   per-player 32-bit subtract/compare logic between the input register
//   and the result register
// reset: millisecond counter and all deadlines zero, all relays off, all
//   players armed, registers at their default values
// rsp stall: the result register holds; the input register still takes
//   one more word, then req.ready drops until rsp drains
module recoil_relay_controller #(
   parameter int PLAYERS = rrc_pkg::PLAYERS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   rrc_req_if.sink                         req,
   rrc_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [rrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rrc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [rrc_pkg::MODE_W-1:0] mode_ff;
   logic                       active_low_ff;
   rrc_pkg::cfg_type           cfg_ff;
   logic                       clear_relays;

   // input register
   logic                         in_valid_ff;
   logic [rrc_pkg::OPCODE_W-1:0] in_opcode_ff;
   logic                         in_player_ff;
   logic                         in_maint_ff;

   // millisecond counter
   logic [rrc_pkg::TIME_W-1:0] time_ff, time_in;

   // result register
   logic                         rsp_valid_ff;
   logic [rrc_pkg::RSP_BITS-1:0] on_ff, pins_ff, armed_ff, disarm_ff, cut_ff;
   logic [rrc_pkg::RSP_BITS-1:0] on_in, pins_in, armed_in, disarm_in, cut_in;

   logic                 advance;
   logic                 is_tick;
   rrc_pkg::evt_type     evt;
   logic [PLAYERS-1:0]   sel;
   rrc_pkg::pstat_type   stat [PLAYERS];

   // pipeline control: result register frees up when empty or taken
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_opcode_ff <= req.opcode;
         in_player_ff <= req.player;
         in_maint_ff  <= req.maintenance;
      end
   end

   // config writes, mode or polarity write clears every relay
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff              <= rrc_pkg::RESET_RELAY_MODE;
         active_low_ff        <= rrc_pkg::RESET_ACTIVE_LOW;
         cfg_ff.pulse_time    <= rrc_pkg::RESET_PULSE_TIME;
         cfg_ff.cooldown_time <= rrc_pkg::RESET_COOLDOWN_TIME;
         cfg_ff.follow_limit  <= rrc_pkg::RESET_FOLLOW_LIMIT;
         cfg_ff.idle_limit    <= rrc_pkg::RESET_IDLE_LIMIT;
      end else if (csr_we) begin
         unique case (csr_index)
            rrc_pkg::CSR_RELAY_MODE:    mode_ff <= csr_wdata[rrc_pkg::MODE_W-1:0];
            rrc_pkg::CSR_ACTIVE_LOW:    active_low_ff <= csr_wdata[0];
            rrc_pkg::CSR_PULSE_TIME:
               cfg_ff.pulse_time <= csr_wdata[rrc_pkg::PULSE_W-1:0];
            rrc_pkg::CSR_COOLDOWN_TIME:
               cfg_ff.cooldown_time <= csr_wdata[rrc_pkg::COOLDOWN_W-1:0];
            rrc_pkg::CSR_FOLLOW_LIMIT:
               cfg_ff.follow_limit <= csr_wdata[rrc_pkg::FOLLOW_W-1:0];
            rrc_pkg::CSR_IDLE_LIMIT:
               cfg_ff.idle_limit <= csr_wdata[rrc_pkg::IDLE_W-1:0];
            default: ;
         endcase
      end
   end

   assign clear_relays = csr_we && (csr_index == rrc_pkg::CSR_RELAY_MODE
                                    || csr_index == rrc_pkg::CSR_ACTIVE_LOW);

   // event seen by every player: the tick advances time before anything else
   assign is_tick = in_opcode_ff == rrc_pkg::OP_TICK;

   always_comb begin
      evt.step   = in_valid_ff && advance;
      evt.opcode = in_opcode_ff;
      evt.maint  = in_maint_ff;
      // unused mode code acts like off
      evt.mode   = (mode_ff == rrc_pkg::MODE_PULSE
                    || mode_ff == rrc_pkg::MODE_FOLLOW) ? mode_ff
                                                        : rrc_pkg::MODE_DISABLED;
      evt.now    = is_tick ? time_ff + rrc_pkg::TIME_W'(1) : time_ff;
      evt.clear  = clear_relays;
      time_in    = evt.now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else if (evt.step) begin
         time_ff <= time_in;
      end
   end

   // one state slice per player; out of range players never match
   for (genvar p = 0; p < PLAYERS; p++) begin : g_player
      assign sel[p] = 32'(in_player_ff) == 32'(p);

      rrc_player u_player (
         .clock (clock),
         .reset (reset),
         .sel   (sel[p]),
         .evt   (evt),
         .cfg   (cfg_ff),
         .stat  (stat[p])
      );
   end

   // only the first two players reach the result word
   for (genvar b = 0; b < rrc_pkg::RSP_BITS; b++) begin : g_bits
      if (b < PLAYERS) begin : g_live
         assign on_in[b]     = stat[b].on;
         assign pins_in[b]   = stat[b].on ^ active_low_ff;
         assign armed_in[b]  = stat[b].armed;
         assign disarm_in[b] = stat[b].disarm;
         assign cut_in[b]    = stat[b].cutoff;
      end else begin : g_absent
         assign on_in[b]     = 1'b0;
         assign pins_in[b]   = 1'b0;
         assign armed_in[b]  = 1'b0;
         assign disarm_in[b] = 1'b0;
         assign cut_in[b]    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (evt.step) begin
         on_ff     <= on_in;
         pins_ff   <= pins_in;
         armed_ff  <= armed_in;
         disarm_ff <= disarm_in;
         cut_ff    <= cut_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.relay_on      = on_ff;
   assign rsp.relay_pins    = pins_ff;
   assign rsp.armed_flags   = armed_ff;
   assign rsp.disarm_events = disarm_ff;
   assign rsp.cutoff_events = cut_ff;

endmodule
